// ----- sv/sptr_pkg.sv -----
package sptr_pkg;

    // field widths
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned TURN_W   = 8;
    localparam int unsigned RESULT_W = 17;

    // quarter-wave sine values, entries scaled by 256
    localparam int unsigned ROM_DEPTH  = 65;
    localparam int unsigned ROM_W      = 9;
    localparam int unsigned ROM_ADDR_W = $clog2(ROM_DEPTH);

    localparam logic [ROM_W-1:0] QUARTER_SINE [ROM_DEPTH] = '{
        9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,  9'd49,
        9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,  9'd97,  9'd103,
        9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136, 9'd142, 9'd147, 9'd152,
        9'd157, 9'd162, 9'd167, 9'd171, 9'd176, 9'd181, 9'd185, 9'd189, 9'd193,
        9'd197, 9'd201, 9'd205, 9'd209, 9'd212, 9'd216, 9'd219, 9'd222, 9'd225,
        9'd228, 9'd231, 9'd234, 9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246,
        9'd248, 9'd249, 9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255,
        9'd255, 9'd256
    };

    typedef enum logic {
        ST_FILL,
        ST_RUN
    } sptr_state_t;

endpackage

// ----- sv/sine_table_point_rotator_top.sv -----
// channel | ports                          | direction | beat contents
// --------+--------------------------------+-----------+------------------------------
// input   | s_valid s_ready s_x_in s_y_in  | in        | point x, y (16b signed),
//         | s_turn                         |           | angle (8b, 256 per turn)
// result  | m_valid m_ready m_x_out m_y_out| out       | rotated x, y (17b signed)
//
// one beat in, one beat out; a new point is taken every cycle while the result beat is not stalled
// the pipe stages are table read, four products, then truncate and sum
// after reset the table ram is loaded from the package constants, all 65 entries,
// s_ready stays low until the load is done
// a stalled result beat holds the whole pipe in place, table read data included
module sine_table_point_rotator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sptr_pkg::COORD_W-1:0]  s_x_in,
    input  logic signed [sptr_pkg::COORD_W-1:0]  s_y_in,
    input  logic        [sptr_pkg::TURN_W-1:0]   s_turn,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sptr_pkg::RESULT_W-1:0] m_x_out,
    output logic signed [sptr_pkg::RESULT_W-1:0] m_y_out
);

    import sptr_pkg::*;

    localparam int unsigned PROD_W = COORD_W + ROM_W + 1;
    localparam int unsigned CNT_W  = $clog2(ROM_DEPTH + 1);

    // table load sequencer
    sptr_state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic             fill_we;

    // pipe control: everything moves together unless the result beat is stuck
    logic pipe_en;
    logic accept;

    // stage 1: table read in flight, factors with their sign already applied
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] xs_fac_reg, ys_fac_reg, xc_fac_reg, yc_fac_reg;
    logic signed [COORD_W-1:0] xs_fac_next, ys_fac_next, xc_fac_next, yc_fac_next;

    // stage 2: products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] xs_prod_reg, ys_prod_reg, xc_prod_reg, yc_prod_reg;
    logic signed [PROD_W-1:0] xs_prod_next, ys_prod_next, xc_prod_next, yc_prod_next;

    // result register
    logic                       out_valid_reg;
    logic signed [RESULT_W-1:0] x_out_reg, y_out_reg, x_out_next, y_out_next;

    // angle folding
    logic [TURN_W-1:0]     cos_turn;
    logic                  sin_neg, cos_neg;
    logic [ROM_ADDR_W-1:0] sin_addr, cos_addr;
    logic [ROM_W-1:0]      sin_rdata, cos_rdata;

    // terms after divide by 256
    logic signed [RESULT_W-1:0] xs_term, ys_term, xc_term, yc_term;

    function automatic logic [ROM_ADDR_W-1:0] fold_addr(input logic [TURN_W-2:0] r);
        logic [TURN_W-1:0] mirrored;
        mirrored = TURN_W'(1 << (TURN_W - 1)) - {1'b0, r};
        // second quarter mirrors around the peak
        if (r[TURN_W-2]) begin
            fold_addr = ROM_ADDR_W'(mirrored);
        end else begin
            fold_addr = ROM_ADDR_W'(r);
        end
    endfunction

    // divide by 256 truncating toward zero
    function automatic logic signed [RESULT_W-1:0] trunc_div(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p + (p[PROD_W-1] ? PROD_W'(signed'(255)) : '0);
        trunc_div = RESULT_W'(biased >>> 8);
    endfunction

    // ---------------------------------------------------------------- load sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            fill_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_we       = 1'b0;
        case (state_reg)
            ST_FILL: begin
                fill_we       = 1'b1;
                fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                // last table entry written this cycle
                if (fill_cnt_reg == CNT_W'(ROM_DEPTH - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                fill_cnt_next = fill_cnt_reg;
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // ---------------------------------------------------------------- handshake
    assign pipe_en = !out_valid_reg || m_ready;
    assign s_ready = pipe_en && (state_reg == ST_RUN);
    assign accept  = s_valid && s_ready;

    // ---------------------------------------------------------------- stage 0
    always_comb begin
        // cosine is the sine term at a quarter turn minus the angle
        cos_turn = TURN_W'(64) - s_turn;
        sin_neg  = s_turn[TURN_W-1];
        cos_neg  = cos_turn[TURN_W-1];
        sin_addr = fold_addr(s_turn[TURN_W-2:0]);
        cos_addr = fold_addr(cos_turn[TURN_W-2:0]);

        // lower half turn negates the factor, most negative value wraps to itself
        xs_fac_next = sin_neg ? COORD_W'(-s_x_in) : s_x_in;
        ys_fac_next = sin_neg ? COORD_W'(-s_y_in) : s_y_in;
        xc_fac_next = cos_neg ? COORD_W'(-s_x_in) : s_x_in;
        yc_fac_next = cos_neg ? COORD_W'(-s_y_in) : s_y_in;
    end

    sptr_ram #(
        .WIDTH (ROM_W),
        .DEPTH (ROM_DEPTH)
    ) u_sine_ram (
        .aclk    (aclk),
        .we      (fill_we),
        .waddr   (fill_cnt_reg[ROM_ADDR_W-1:0]),
        .wdata   (QUARTER_SINE[fill_cnt_reg[ROM_ADDR_W-1:0]]),
        .re      (accept),
        .raddr_a (sin_addr),
        .raddr_b (cos_addr),
        .rdata_a (sin_rdata),
        .rdata_b (cos_rdata)
    );

    // ---------------------------------------------------------------- stage 1
    always_comb begin
        xs_prod_next = xs_fac_reg * $signed({1'b0, sin_rdata});
        ys_prod_next = ys_fac_reg * $signed({1'b0, sin_rdata});
        xc_prod_next = xc_fac_reg * $signed({1'b0, cos_rdata});
        yc_prod_next = yc_fac_reg * $signed({1'b0, cos_rdata});
    end

    // ---------------------------------------------------------------- stage 2
    always_comb begin
        xs_term    = trunc_div(xs_prod_reg);
        ys_term    = trunc_div(ys_prod_reg);
        xc_term    = trunc_div(xc_prod_reg);
        yc_term    = trunc_div(yc_prod_reg);
        x_out_next = xc_term - ys_term;
        y_out_next = xs_term + yc_term;
    end

    // ---------------------------------------------------------------- pipe registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            xs_fac_reg <= xs_fac_next;
            ys_fac_reg <= ys_fac_next;
            xc_fac_reg <= xc_fac_next;
            yc_fac_reg <= yc_fac_next;
        end
        if (pipe_en) begin
            xs_prod_reg <= xs_prod_next;
            ys_prod_reg <= ys_prod_next;
            xc_prod_reg <= xc_prod_next;
            yc_prod_reg <= yc_prod_next;
            x_out_reg   <= x_out_next;
            y_out_reg   <= y_out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_x_out = x_out_reg;
    assign m_y_out = y_out_reg;

    // ---------------------------------------------------------------- assertions
    a_no_accept_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !s_ready)
        else $error("input taken while table load runs");

    a_load_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (fill_cnt_reg == CNT_W'(ROM_DEPTH)))
        else $error("run state entered with table not fully loaded");

    a_accept_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted beat missing from stage 1");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipe moved during result stall");

    a_stage_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && s2_valid_reg) |=> m_valid)
        else $error("stage 2 beat lost on its way to the result register");

endmodule

// ----- sv/sptr_ram.sv -----
module sptr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- verif/sine_table_point_rotator_top_test.sv -----
module sine_table_point_rotator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // run length and pacing
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_HEAD  = 300;
    localparam int PRESSURE_RUN = 60;
    localparam int RANDOM_TAIL  = 570;

    // quarter-wave sine, 256 = 1.0, kept apart from the block's own table
    localparam int SINE_Q [65] = '{
          0,   6,  12,  18,  25,  31,  37,  43,  49,  56,  62,  68,  74,
         80,  86,  92,  97, 103, 109, 115, 120, 126, 131, 136, 142, 147,
        152, 157, 162, 167, 171, 176, 181, 185, 189, 193, 197, 201, 205,
        209, 212, 216, 219, 222, 225, 228, 231, 234, 236, 238, 241, 243,
        244, 246, 248, 249, 251, 252, 253, 254, 254, 255, 255, 255, 256
    };

    // quadrant edges and their neighbors
    localparam int TURN_EDGES [11] = '{0, 1, 63, 64, 65, 127, 128, 129, 191, 192, 255};

    typedef struct {
        logic signed [sptr_pkg::RESULT_W-1:0] x_out;
        logic signed [sptr_pkg::RESULT_W-1:0] y_out;
    } rotated_point_t;

    // predicts each rotated point and holds the ones still owed
    class rotation_scoreboard;
        rotated_point_t rotated_q[$];
        int unsigned    errors;

        function int scaled_sine(int factor, int ang);
            int a;
            int f;
            a = ang & 255;
            f = factor;
            // lower half turn flips the factor, the most negative value wraps onto itself
            if (a >= 128) begin
                a = a - 128;
                if (f != -32768) begin
                    f = -f;
                end
            end
            // second quadrant mirrors back onto the first
            if (a >= 64) begin
                a = 128 - a;
            end
            return (f * SINE_Q[a]) / 256;
        endfunction

        function int scaled_cosine(int factor, int ang);
            return scaled_sine(factor, (64 - ang) & 255);
        endfunction

        function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                                 logic [7:0] ang);
            int xi;
            int yi;
            int ai;
            int nx;
            int ny;
            rotated_point_t p;
            xi = x;
            yi = y;
            ai = ang;
            nx = scaled_cosine(xi, ai) - scaled_sine(yi, ai);
            ny = scaled_sine(xi, ai) + scaled_cosine(yi, ai);
            p.x_out = nx[16:0];
            p.y_out = ny[16:0];
            rotated_q.push_back(p);
        endfunction

        function void check_rotated(logic signed [16:0] x, logic signed [16:0] y);
            rotated_point_t p;
            if (rotated_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with none owed, x_out %0d y_out %0d",
                         $time, x, y);
                return;
            end
            p = rotated_q.pop_front();
            if (x !== p.x_out) begin
                errors++;
                $display("%0t: x_out expected %0d actual %0d", $time, p.x_out, x);
            end
            if (y !== p.y_out) begin
                errors++;
                $display("%0t: y_out expected %0d actual %0d", $time, p.y_out, y);
            end
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction
    endclass

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [sptr_pkg::COORD_W-1:0]  s_x_in;
    logic signed [sptr_pkg::COORD_W-1:0]  s_y_in;
    logic        [sptr_pkg::TURN_W-1:0]   s_turn;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [sptr_pkg::RESULT_W-1:0] m_x_out;
    logic signed [sptr_pkg::RESULT_W-1:0] m_y_out;

    rotation_scoreboard sb;

    // sender pacing: burst length left, and a switch for gapless sending
    int burst_left;
    bit steady_send;
    // raised by the stimulus, cleared by the receiver once its hold-off is done
    bit hold_request;
    int cycle_count = 0;

    sine_table_point_rotator_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_x_in  (s_x_in),
        .s_y_in  (s_y_in),
        .s_turn  (s_turn),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_x_out (m_x_out),
        .m_y_out (m_y_out)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog, counts every cycle including the table load after reset
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sine_table_point_rotator_top regression: fail");
            $finish;
        end
    end

    // both channels sampled at the edge, before any driver update lands
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) begin
                sb.note_point(s_x_in, s_y_in, s_turn);
            end
            if (m_valid === 1'b1 && m_ready) begin
                sb.check_rotated(m_x_out, m_y_out);
            end
        end
    end

    // receiver: segments of random stall patterns, plus one long hold-off on request
    initial begin
        int seg_len;
        int seg_kind;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            seg_len  = $urandom_range(10, 120);
            seg_kind = $urandom_range(0, 3);
            for (int i = 0; i < seg_len; i++) begin
                if (hold_request) begin
                    // long hold-off so the pipe fills and back-pressures the input
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_request = 1'b0;
                end
                case (seg_kind)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 1) != 0);
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    // idle cycles after the beat just taken; zero keeps the burst going
    function automatic int next_gap();
        if (steady_send) begin
            return 0;
        end
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 40);
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(10, 30);
        end
        return $urandom_range(1, 6);
    endfunction

    // offers one point and holds it until the handshake completes
    task automatic send_point(input int x, input int y, input int ang);
        int gap;
        s_valid <= 1'b1;
        s_x_in  <= x[15:0];
        s_y_in  <= y[15:0];
        s_turn  <= ang[7:0];
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        gap = next_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // mostly full-range coordinates, with the extremes and small values mixed in
    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1: return $urandom_range(0, 600) - 300;
            default: return $signed($urandom() & 32'hffff) - (($urandom() & 32'h0) );
        endcase
    endfunction

    function automatic int pick_turn();
        if ($urandom_range(0, 4) == 0) begin
            return TURN_EDGES[$urandom_range(0, 10)];
        end
        return $urandom_range(0, 255);
    endfunction

    // input side goes quiet until every owed result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        // let the monitor note a beat taken at the edge just passed
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        sb           = new();
        burst_left   = 0;
        steady_send  = 1'b0;
        hold_request = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_x_in  <= '0;
        s_y_in  <= '0;
        s_turn  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: coordinate extremes, every quadrant edge, wrap of the most
        // negative factor in both the sine and the cosine term
        send_point(32767, 32767, 0);
        send_point(-32768, -32768, 0);
        send_point(-32768, -32768, 128);
        send_point(-32768, 32767, 64);
        send_point(32767, -32768, 192);
        send_point(-32768, -32768, 255);
        send_point(-32768, -32768, 129);
        send_point(-32768, -32768, 192);
        send_point(-32768, -32768, 64);
        send_point(-32768, 32767, 65);
        send_point(32767, -32768, 127);
        send_point(-32768, -32768, 191);
        send_point(100, -200, 193);
        send_point(12345, -23456, 63);
        send_point(32767, 32767, 32);
        send_point(-32768, 32767, 160);
        send_point(0, -32768, 96);
        send_point(-1, 1, 200);
        send_point(1, -1, 100);
        send_point(-1, -1, 1);
        send_point(0, 0, 37);

        for (int i = 0; i < RANDOM_HEAD; i++) begin
            send_point(pick_coord(), pick_coord(), pick_turn());
        end

        // sender pauses until the block has handed back everything
        drain_results();

        // receiver holds off while points keep coming with no gaps
        hold_request = 1'b1;
        steady_send  = 1'b1;
        for (int i = 0; i < PRESSURE_RUN; i++) begin
            send_point(pick_coord(), pick_coord(), pick_turn());
        end
        steady_send = 1'b0;

        for (int i = 0; i < RANDOM_TAIL; i++) begin
            send_point(pick_coord(), pick_coord(), pick_turn());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sine_table_point_rotator_top regression: pass");
        end else begin
            $display("sine_table_point_rotator_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sptr_pkg.sv
sv/sptr_ram.sv
sv/sine_table_point_rotator_top.sv
verif/sine_table_point_rotator_top_test.sv
